// ===== design/source_token_scanner_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the source token scanner
// Clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_TOP_ASSERT_SVH

// same-cycle implication
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sts_pkg.sv =====
// ---------------------------------------------------------------------------
// sts_pkg
// Types, token codes and keyword table for the source token scanner.
// ---------------------------------------------------------------------------
package sts_pkg;

    localparam logic [5:0] KIND_IDENT  = 6'd0;
    localparam logic [5:0] KIND_NUMBER = 6'd1;
    localparam logic [5:0] KIND_STRING = 6'd2;
    localparam logic [5:0] KIND_KW0    = 6'd3;
    localparam logic [5:0] KIND_NOT    = 6'd15;
    localparam logic [5:0] KIND_PLUS   = 6'd16;
    localparam logic [5:0] KIND_MINUS  = 6'd17;
    localparam logic [5:0] KIND_MUL    = 6'd18;
    localparam logic [5:0] KIND_DIV    = 6'd19;
    localparam logic [5:0] KIND_MOD    = 6'd20;
    localparam logic [5:0] KIND_AND    = 6'd21;
    localparam logic [5:0] KIND_OR     = 6'd22;
    localparam logic [5:0] KIND_LT     = 6'd23;
    localparam logic [5:0] KIND_LE     = 6'd24;
    localparam logic [5:0] KIND_GT     = 6'd25;
    localparam logic [5:0] KIND_GE     = 6'd26;
    localparam logic [5:0] KIND_EQ     = 6'd27;
    localparam logic [5:0] KIND_NE     = 6'd28;
    localparam logic [5:0] KIND_ASSIGN = 6'd29;
    localparam logic [5:0] KIND_COMMA  = 6'd30;
    localparam logic [5:0] KIND_SEMI   = 6'd31;
    localparam logic [5:0] KIND_LPAR   = 6'd32;
    localparam logic [5:0] KIND_RPAR   = 6'd33;
    localparam logic [5:0] KIND_LBRK   = 6'd34;
    localparam logic [5:0] KIND_RBRK   = 6'd35;
    localparam logic [5:0] KIND_LBRC   = 6'd36;
    localparam logic [5:0] KIND_RBRC   = 6'd37;
    localparam logic [5:0] KIND_BAD    = 6'd38;
    localparam logic [5:0] KIND_END    = 6'd39;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    // pending relational operator
    localparam logic [2:0] POP_NONE = 3'd0;
    localparam logic [2:0] POP_LT   = 3'd1;
    localparam logic [2:0] POP_GT   = 3'd2;
    localparam logic [2:0] POP_NOT  = 3'd3;
    localparam logic [2:0] POP_EQ   = 3'd4;

    // string flag bits
    localparam int FLAG_ERR    = 0;
    localparam int FLAG_WANT_N = 1;
    localparam int FLAG_WANT_D = 2;

    typedef enum logic [10:0] {
        MODE_NORMAL     = 11'b000_0000_0001,
        MODE_IDENT      = 11'b000_0000_0010,
        MODE_NUMBER     = 11'b000_0000_0100,
        MODE_STRING     = 11'b000_0000_1000,
        MODE_SLASH      = 11'b000_0001_0000,
        MODE_LINE_CMT   = 11'b000_0010_0000,
        MODE_BLOCK_CMT  = 11'b000_0100_0000,
        MODE_BLOCK_STAR = 11'b000_1000_0000,
        MODE_AMP        = 11'b001_0000_0000,
        MODE_BAR        = 11'b010_0000_0000,
        MODE_REL        = 11'b100_0000_0000
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        err;
        logic        last;
    } rec_t;

    // up to three results made by one byte
    typedef struct packed {
        logic [1:0]      count;
        rec_t [2:0]      recs;
    } push_t;

    function automatic rec_t mk_rec(logic [5:0] kind, logic [15:0] start,
                                    logic [15:0] len, logic [15:0] line, logic err);
        rec_t r;
        r.kind  = kind;
        r.start = start;
        r.len   = len;
        r.line  = line;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] inc_sat(logic [15:0] v, logic [15:0] top);
        return (v < top) ? v + 16'd1 : top;
    endfunction

    function automatic logic is_word_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [3:0] kw_len(int k);
        logic [3:0] l;
        case (k)
            0: l = 4'd4;  1: l = 4'd5;  2: l = 4'd3;  3: l = 4'd5;
            4: l = 4'd8;  5: l = 4'd2;  6: l = 4'd4;  7: l = 4'd6;
            8: l = 4'd6;  9: l = 4'd6;  10: l = 4'd5; 11: l = 4'd4;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    // byte 0 in bits [7:0]
    function automatic logic [63:0] kw_text(int k);
        logic [63:0] t;
        case (k)
            0:  t = {32'h0, "niam"};
            1:  t = {24'h0, "tsnoc"};
            2:  t = {40'h0, "tni"};
            3:  t = {24'h0, "kaerb"};
            4:  t = "eunitnoc";
            5:  t = {48'h0, "fi"};
            6:  t = {32'h0, "esle"};
            7:  t = {16'h0, "tniteg"};
            8:  t = {16'h0, "ftnirp"};
            9:  t = {16'h0, "nruter"};
            10: t = {24'h0, "elihw"};
            11: t = {32'h0, "diov"};
            default: t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic [5:0] word_kind(logic [63:0] buf8, logic [15:0] len);
        logic [5:0]  kind;
        logic        hit;
        logic [63:0] t;
        kind = KIND_IDENT;
        for (int k = 11; k >= 0; k--) begin
            t   = kw_text(k);
            hit = (len == {12'h0, kw_len(k)});
            for (int i = 0; i < 8; i++) begin
                if (i < int'(kw_len(k)) && buf8[8*i +: 8] != t[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = KIND_KW0 + 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [5:0] single_symbol(logic [7:0] c);
        logic [5:0] k;
        case (c)
            "+": k = KIND_PLUS;   "-": k = KIND_MINUS;  "*": k = KIND_MUL;
            "%": k = KIND_MOD;    ",": k = KIND_COMMA;  ";": k = KIND_SEMI;
            "(": k = KIND_LPAR;   ")": k = KIND_RPAR;   "[": k = KIND_LBRK;
            "]": k = KIND_RBRK;   "{": k = KIND_LBRC;   "}": k = KIND_RBRC;
            default: k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] rel_single(logic [2:0] p);
        logic [5:0] k;
        case (p)
            POP_LT:  k = KIND_LT;
            POP_GT:  k = KIND_GT;
            POP_NOT: k = KIND_NOT;
            POP_EQ:  k = KIND_ASSIGN;
            default: k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] rel_double(logic [2:0] p);
        logic [5:0] k;
        case (p)
            POP_LT:  k = KIND_LE;
            POP_GT:  k = KIND_GE;
            POP_NOT: k = KIND_NE;
            POP_EQ:  k = KIND_EQ;
            default: k = KIND_BAD;
        endcase
        return k;
    endfunction

endpackage

// ===== design/sts_core.sv =====
// ---------------------------------------------------------------------------
// sts_core
// Scanner state and per-byte next-state logic; builds up to three results.
// ---------------------------------------------------------------------------
module sts_core
    import sts_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = 65536,
    parameter int KEYWORD_BYTES  = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_byte,
    input  logic       end_of_text,
    output push_t      push
);

    localparam int IW = $clog2(KEYWORD_BYTES);
    localparam logic [15:0] OFF_TOP =
        16'(((MAX_TEXT_BYTES - 1) > 65535) ? 65535 : (MAX_TEXT_BYTES - 1));

    mode_t                          mode_reg, mode_next;
    logic [KEYWORD_BYTES-1:0][7:0]  kbuf_reg, kbuf_next;
    logic [15:0]                    len_reg, len_next;
    logic [15:0]                    start_reg, start_next;
    logic [15:0]                    off_reg, off_next;
    logic [15:0]                    line_reg, line_next;
    logic [2:0]                     flags_reg, flags_next;
    logic [2:0]                     pop_reg, pop_next;

    always_comb
    begin
        logic [7:0]  c;
        logic [15:0] pos;
        logic        redo;
        logic [1:0]  cnt;
        rec_t [2:0]  r;
        logic        fin_v;
        rec_t        fin_r;

        c          = char_byte;
        pos        = off_reg;
        redo       = 1'b0;
        cnt        = 2'd0;
        r          = '0;
        mode_next  = mode_reg;
        kbuf_next  = kbuf_reg;
        len_next   = len_reg;
        start_next = start_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        flags_next = flags_reg;
        pop_next   = pop_reg;
        fin_v      = 1'b0;
        fin_r      = '0;

        // first pass: modes that wait on this byte
        case (mode_reg)
            MODE_NORMAL: redo = 1'b1;
            MODE_IDENT:
            begin
                if (is_word_start(c) || is_dec(c)) begin
                    if (len_next < 16'(KEYWORD_BYTES)) begin
                        kbuf_next[len_next[IW-1:0]] = c;
                    end
                    len_next = inc_sat(len_next, SAT16);
                end else begin
                    fin_v = 1'b1;
                    fin_r = mk_rec(word_kind(kbuf_next[7:0], len_next), start_next,
                                   len_next, line_next, 1'b0);
                    redo  = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_dec(c)) begin
                    len_next = inc_sat(len_next, SAT16);
                end else begin
                    fin_v = 1'b1;
                    fin_r = mk_rec(KIND_NUMBER, start_next, len_next, line_next, 1'b0);
                    redo  = 1'b1;
                end
            end
            MODE_STRING:
            begin
                len_next = inc_sat(len_next, SAT16);
                if (c == "\"") begin
                    if (flags_next[FLAG_WANT_N] || flags_next[FLAG_WANT_D]) begin
                        flags_next[FLAG_ERR] = 1'b1;
                    end
                    r[cnt] = mk_rec(KIND_STRING, start_next, len_next, line_next,
                                    flags_next[FLAG_ERR]);
                    cnt = cnt + 2'd1;
                    mode_next = MODE_NORMAL;
                end else begin
                    if (flags_next[FLAG_WANT_N] && c != "n") flags_next[FLAG_ERR] = 1'b1;
                    if (flags_next[FLAG_WANT_D] && c != "d") flags_next[FLAG_ERR] = 1'b1;
                    flags_next[FLAG_WANT_N] = 1'b0;
                    flags_next[FLAG_WANT_D] = 1'b0;
                    if (c == 8'd32 || c == 8'd33 || (c >= 8'd40 && c <= 8'd126)) begin
                        if (c == "\\") flags_next[FLAG_WANT_N] = 1'b1;
                    end else if (c == "%") begin
                        flags_next[FLAG_WANT_D] = 1'b1;
                    end else begin
                        flags_next[FLAG_ERR] = 1'b1;
                    end
                end
            end
            MODE_SLASH:
            begin
                if (c == "/") begin
                    mode_next = MODE_LINE_CMT;
                end else if (c == "*") begin
                    mode_next = MODE_BLOCK_CMT;
                end else begin
                    fin_v = 1'b1;
                    fin_r = mk_rec(KIND_DIV, start_next, 16'd1, line_next, 1'b0);
                    redo  = 1'b1;
                end
            end
            MODE_LINE_CMT:
            begin
                if (c == "\n") begin
                    mode_next = MODE_NORMAL;
                    redo      = 1'b1;
                end
            end
            MODE_BLOCK_CMT, MODE_BLOCK_STAR:
            begin
                if (c == "\n") line_next = inc_sat(line_next, SAT16);
                if (mode_reg == MODE_BLOCK_STAR && c == "/") begin
                    mode_next = MODE_NORMAL;
                end else begin
                    mode_next = (c == "*") ? MODE_BLOCK_STAR : MODE_BLOCK_CMT;
                end
            end
            MODE_AMP, MODE_BAR:
            begin
                if (c == ((mode_reg == MODE_AMP) ? "&" : "|")) begin
                    r[cnt] = mk_rec((mode_reg == MODE_AMP) ? KIND_AND : KIND_OR,
                                    start_next, 16'd2, line_next, 1'b0);
                    cnt = cnt + 2'd1;
                    mode_next = MODE_NORMAL;
                end else begin
                    fin_v = 1'b1;
                    fin_r = mk_rec(KIND_BAD, start_next, 16'd1, line_next, 1'b0);
                    redo  = 1'b1;
                end
            end
            MODE_REL:
            begin
                if (c == "=" && pop_next >= POP_LT && pop_next <= POP_EQ) begin
                    r[cnt] = mk_rec(rel_double(pop_next), start_next, 16'd2,
                                    line_next, 1'b0);
                    cnt = cnt + 2'd1;
                    mode_next = MODE_NORMAL;
                    pop_next  = POP_NONE;
                end else begin
                    fin_v = 1'b1;
                    fin_r = mk_rec(rel_single(pop_next), start_next, 16'd1,
                                   line_next, 1'b0);
                    redo  = 1'b1;
                end
            end
            default: redo = 1'b1;
        endcase

        if (fin_v) begin
            r[cnt]    = fin_r;
            cnt       = cnt + 2'd1;
            mode_next = MODE_NORMAL;
            pop_next  = POP_NONE;
        end

        // second pass: byte seen from the between-tokens state
        if (redo) begin
            mode_next  = MODE_NORMAL;
            start_next = pos;
            len_next   = 16'd1;
            if (c == "\n") begin
                line_next = inc_sat(line_next, SAT16);
            end else if (c == " " || c == "\t" || c == "\r") begin
                mode_next = MODE_NORMAL;
            end else if (is_word_start(c)) begin
                mode_next   = MODE_IDENT;
                kbuf_next[0] = c;
            end else if (is_dec(c)) begin
                mode_next = MODE_NUMBER;
            end else if (c == "\"") begin
                mode_next  = MODE_STRING;
                flags_next = 3'b000;
            end else if (c == "<" || c == ">" || c == "!" || c == "=") begin
                mode_next = MODE_REL;
                pop_next  = (c == "<") ? POP_LT : (c == ">") ? POP_GT :
                            (c == "!") ? POP_NOT : POP_EQ;
            end else if (c == "/") begin
                mode_next = MODE_SLASH;
            end else if (c == "&") begin
                mode_next = MODE_AMP;
            end else if (c == "|") begin
                mode_next = MODE_BAR;
            end else begin
                r[cnt] = mk_rec(single_symbol(c), pos, 16'd1, line_next, 1'b0);
                cnt    = cnt + 2'd1;
            end
        end

        off_next = inc_sat(pos, OFF_TOP);

        if (end_of_text) begin
            // flush whatever token is still open
            case (mode_next)
                MODE_IDENT:
                begin
                    r[cnt] = mk_rec(word_kind(kbuf_next[7:0], len_next), start_next,
                                    len_next, line_next, 1'b0);
                    cnt = cnt + 2'd1;
                end
                MODE_NUMBER:
                begin
                    r[cnt] = mk_rec(KIND_NUMBER, start_next, len_next, line_next, 1'b0);
                    cnt = cnt + 2'd1;
                end
                MODE_STRING:
                begin
                    r[cnt] = mk_rec(KIND_STRING, start_next, len_next, line_next, 1'b1);
                    cnt = cnt + 2'd1;
                end
                MODE_SLASH:
                begin
                    r[cnt] = mk_rec(KIND_DIV, start_next, 16'd1, line_next, 1'b0);
                    cnt = cnt + 2'd1;
                end
                MODE_AMP, MODE_BAR:
                begin
                    r[cnt] = mk_rec(KIND_BAD, start_next, 16'd1, line_next, 1'b0);
                    cnt = cnt + 2'd1;
                end
                MODE_REL:
                begin
                    r[cnt] = mk_rec(rel_single(pop_next), start_next, 16'd1,
                                    line_next, 1'b0);
                    cnt = cnt + 2'd1;
                end
                default: cnt = cnt;
            endcase
            r[cnt] = mk_rec(KIND_END, off_next, 16'd0, line_next, 1'b0);
            cnt    = cnt + 2'd1;
            // back to the reset state for the next text
            mode_next  = MODE_NORMAL;
            len_next   = 16'd0;
            start_next = 16'd0;
            off_next   = 16'd0;
            line_next  = 16'd1;
            flags_next = 3'b000;
            pop_next   = POP_NONE;
        end

        for (int i = 0; i < 3; i++) begin
            r[i].last = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
        end
        push.count = cnt;
        push.recs  = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_NORMAL;
            len_reg   <= 16'd0;
            start_reg <= 16'd0;
            off_reg   <= 16'd0;
            line_reg  <= 16'd1;
            flags_reg <= 3'b000;
            pop_reg   <= POP_NONE;
        end else if (accept) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            flags_reg <= flags_next;
            pop_reg   <= pop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            kbuf_reg <= kbuf_next;
        end
    end

endmodule

// ===== design/sts_outq.sv =====
// ---------------------------------------------------------------------------
// sts_outq
// Four-entry result queue, head at entry 0; takes up to three words a cycle.
// ---------------------------------------------------------------------------
`include "source_token_scanner_top_assert.svh"

module sts_outq
    import sts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_en,
    input  push_t push,
    input  logic  pop,
    output logic  room,
    output logic  head_valid,
    output rec_t  head
);

    rec_t [3:0] q_reg, q_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] push_n;

    assign push_n     = push_en ? push.count : 2'd0;
    assign room       = (cnt_reg < 3'd2);
    assign head_valid = (cnt_reg != 3'd0);
    assign head       = q_reg[0];

    always_comb
    begin
        logic [2:0] keep;
        logic [2:0] j;
        logic [2:0] k;
        keep   = cnt_reg - {2'b00, pop};
        q_next = q_reg;
        for (int i = 0; i < 4; i++) begin
            j = 3'(i) + {2'b00, pop};
            k = 3'(i) - keep;
            if (j < cnt_reg) begin
                q_next[i] = q_reg[j[1:0]];
            end else if (3'(i) >= keep && k < {1'b0, push_n}) begin
                q_next[i] = push.recs[k[1:0]];
            end
        end
        cnt_next = keep + {1'b0, push_n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    `STS_ASSERT_NOW(a_no_overflow, push_en, cnt_reg + 3'd3 <= 3'd4 + {2'b00, pop},
                    "result queue could overflow")
    `STS_ASSERT_NOW(a_pop_nonempty, pop, cnt_reg != 3'd0, "pop from empty result queue")
    `STS_ASSERT_NEXT(a_drain, pop && !push_en && cnt_reg == 3'd1, cnt_reg == 3'd0,
                     "last word not drained")

endmodule

// ===== design/source_token_scanner_top.sv =====
// ---------------------------------------------------------------------------
// source_token_scanner_top
// Streaming lexer for a small C subset, one source byte per word.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one byte of text per word, with
// end_of_text set on the final byte. Output channel (out_valid / out_stall):
// one token per word with kind, start offset, length, line and format error;
// last_of_run marks the final token caused by one input byte.
// Output: tokens are registered into the result queue and show on the
// outputs from its head. A byte that needs lookahead (identifier, number,
// / & | < > ! =) emits its token when the following byte arrives.
// Throughput: one byte per cycle while the receiver does not stall and each
// byte yields at most one token. A byte yields up to three tokens; the
// four-entry queue drains one per unstalled cycle; in_stall rises while it
// holds two or more words, so bursts of multi-token bytes stall the input.
// Reset: scanner returns to between-tokens, offset 0, line 1, queue empty.
// The same state is restored after the end token of each text.
// Receiver stall: the head token holds on the outputs; the queue fills and
// then stalls the input side.
// ---------------------------------------------------------------------------
module source_token_scanner_top
    import sts_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = 65536,
    parameter int KEYWORD_BYTES  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        format_error,
    output logic        last_of_run
);

    logic  accept;
    logic  room;
    logic  pop;
    push_t push;
    rec_t  head;

    assign in_stall = !room;
    assign accept   = in_valid && room;
    assign pop      = out_valid && !out_stall;

    // per-byte scan step
    sts_core #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .KEYWORD_BYTES  (KEYWORD_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_byte   (char_byte),
        .end_of_text (end_of_text),
        .push        (push)
    );

    // result register / queue
    sts_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (accept),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign token_kind   = head.kind;
    assign start_offset = head.start;
    assign token_length = head.len;
    assign line_number  = head.line;
    assign format_error = head.err;
    assign last_of_run  = head.last;

endmodule

// ===== tb/source_token_scanner_top_test.sv =====
// ---------------------------------------------------------------------------
// source_token_scanner_top_test
// Checks the streaming lexer against a token predictor kept in the bench.
// Every byte taken updates the predictor, which queues the tokens it causes.
// Each token that leaves the block is compared field by field with the
// oldest queued token.
// ---------------------------------------------------------------------------
module source_token_scanner_top_test
    import sts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        err;
        logic        last;
    } token_t;

    // Token predictor plus the queue of tokens still owed by the block.
    class token_scoreboard;
        mode_t       mode;
        logic [7:0]  word_buf [8];
        logic [15:0] cur_len;
        logic [15:0] tok_start;
        logic [15:0] offset;
        logic [15:0] line;
        logic [2:0]  flags;
        logic [2:0]  pend_op;
        token_t      owed_tokens [$];
        token_t      step_tokens [$];
        int          mismatches;
        int          tokens_seen;

        function void clear_state();
            mode = MODE_NORMAL;
            foreach (word_buf[i]) word_buf[i] = 8'h00;
            cur_len = 16'd0;
            tok_start = 16'd0;
            offset = 16'd0;
            line = 16'd1;
            flags = 3'b000;
            pend_op = POP_NONE;
        endfunction

        function void put(logic [5:0] kind, logic [15:0] start, logic [15:0] len,
                          logic err);
            token_t t;
            if (step_tokens.size() >= 3) return;
            t.kind = kind;
            t.start = start;
            t.len = len;
            t.line = line;
            t.err = err;
            t.last = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v < SAT16) ? v + 16'd1 : v;
        endfunction

        function logic alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function logic digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // identifier or one of the twelve keywords
        function logic [5:0] ident_kind();
            string names [12];
            string s;
            names = '{"main", "const", "int", "break", "continue", "if", "else",
                      "getint", "printf", "return", "while", "void"};
            if (cur_len > 16'd8) return KIND_IDENT;
            s = "";
            for (int i = 0; i < int'(cur_len); i++) s = {s, string'(word_buf[i])};
            foreach (names[k])
                if (names[k] == s) return KIND_KW0 + 6'(k);
            return KIND_IDENT;
        endfunction

        function logic [5:0] op_single();
            case (pend_op)
                POP_LT:  return KIND_LT;
                POP_GT:  return KIND_GT;
                POP_NOT: return KIND_NOT;
                POP_EQ:  return KIND_ASSIGN;
                default: return KIND_BAD;
            endcase
        endfunction

        function logic [5:0] op_double();
            case (pend_op)
                POP_LT:  return KIND_LE;
                POP_GT:  return KIND_GE;
                POP_NOT: return KIND_NE;
                default: return KIND_EQ;
            endcase
        endfunction

        function void flush_pending();
            case (mode)
                MODE_IDENT:  put(ident_kind(), tok_start, cur_len, 1'b0);
                MODE_NUMBER: put(KIND_NUMBER, tok_start, cur_len, 1'b0);
                MODE_STRING: put(KIND_STRING, tok_start, cur_len, 1'b1);
                MODE_SLASH:  put(KIND_DIV, tok_start, 16'd1, 1'b0);
                MODE_AMP, MODE_BAR: put(KIND_BAD, tok_start, 16'd1, 1'b0);
                MODE_REL:    put(op_single(), tok_start, 16'd1, 1'b0);
                default: ;
            endcase
            mode = MODE_NORMAL;
            pend_op = POP_NONE;
        endfunction

        function logic [5:0] punct(logic [7:0] c);
            case (c)
                "+": return KIND_PLUS;   "-": return KIND_MINUS;
                "*": return KIND_MUL;    "%": return KIND_MOD;
                ",": return KIND_COMMA;  ";": return KIND_SEMI;
                "(": return KIND_LPAR;   ")": return KIND_RPAR;
                "[": return KIND_LBRK;   "]": return KIND_RBRK;
                "{": return KIND_LBRC;   "}": return KIND_RBRC;
                default: return KIND_BAD;
            endcase
        endfunction

        function void start_token(logic [7:0] c, logic [15:0] pos);
            tok_start = pos;
            cur_len = 16'd1;
            if (c == 8'h0A) line = bump(line);
            else if (c == " " || c == 8'h09 || c == 8'h0D) ;
            else if (alpha(c)) begin
                mode = MODE_IDENT;
                word_buf[0] = c;
            end
            else if (digit(c)) mode = MODE_NUMBER;
            else if (c == "\"") begin
                mode = MODE_STRING;
                flags = 3'b000;
            end
            else if (c == "<" || c == ">" || c == "!" || c == "=") begin
                mode = MODE_REL;
                pend_op = (c == "<") ? POP_LT : (c == ">") ? POP_GT :
                          (c == "!") ? POP_NOT : POP_EQ;
            end
            else if (c == "/") mode = MODE_SLASH;
            else if (c == "&") mode = MODE_AMP;
            else if (c == "|") mode = MODE_BAR;
            else put(punct(c), pos, 16'd1, 1'b0);
        endfunction

        function void string_char(logic [7:0] c);
            if (flags[FLAG_WANT_N] && c != "n") flags[FLAG_ERR] = 1'b1;
            if (flags[FLAG_WANT_D] && c != "d") flags[FLAG_ERR] = 1'b1;
            flags[FLAG_WANT_N] = 1'b0;
            flags[FLAG_WANT_D] = 1'b0;
            if (c == 8'd32 || c == 8'd33 || (c >= 8'd40 && c <= 8'd126)) begin
                if (c == "\\") flags[FLAG_WANT_N] = 1'b1;
            end
            else if (c == "%") flags[FLAG_WANT_D] = 1'b1;
            else flags[FLAG_ERR] = 1'b1;
        endfunction

        // note one accepted byte
        function void note_byte(logic [7:0] c, logic eot);
            logic [15:0] pos;
            logic        rescan;
            pos = offset;
            rescan = 1'b0;
            step_tokens.delete();
            case (mode)
                MODE_IDENT:
                    if (alpha(c) || digit(c)) begin
                        if (cur_len < 16'd8) word_buf[cur_len[2:0]] = c;
                        cur_len = bump(cur_len);
                    end
                    else begin
                        flush_pending();
                        rescan = 1'b1;
                    end
                MODE_NUMBER:
                    if (digit(c)) cur_len = bump(cur_len);
                    else begin
                        flush_pending();
                        rescan = 1'b1;
                    end
                MODE_STRING: begin
                    cur_len = bump(cur_len);
                    if (c == "\"") begin
                        if (flags[FLAG_WANT_N] || flags[FLAG_WANT_D]) flags[FLAG_ERR] = 1'b1;
                        put(KIND_STRING, tok_start, cur_len, flags[FLAG_ERR]);
                        mode = MODE_NORMAL;
                    end
                    else string_char(c);
                end
                MODE_SLASH:
                    if (c == "/") mode = MODE_LINE_CMT;
                    else if (c == "*") mode = MODE_BLOCK_CMT;
                    else begin
                        flush_pending();
                        rescan = 1'b1;
                    end
                MODE_LINE_CMT:
                    if (c == 8'h0A) begin
                        mode = MODE_NORMAL;
                        rescan = 1'b1;
                    end
                MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
                    if (c == 8'h0A) line = bump(line);
                    if (mode == MODE_BLOCK_STAR && c == "/") mode = MODE_NORMAL;
                    else mode = (c == "*") ? MODE_BLOCK_STAR : MODE_BLOCK_CMT;
                end
                MODE_AMP, MODE_BAR:
                    if (c == ((mode == MODE_AMP) ? "&" : "|")) begin
                        put((mode == MODE_AMP) ? KIND_AND : KIND_OR, tok_start, 16'd2,
                            1'b0);
                        mode = MODE_NORMAL;
                    end
                    else begin
                        flush_pending();
                        rescan = 1'b1;
                    end
                MODE_REL:
                    if (c == "=") begin
                        put(op_double(), tok_start, 16'd2, 1'b0);
                        mode = MODE_NORMAL;
                        pend_op = POP_NONE;
                    end
                    else begin
                        flush_pending();
                        rescan = 1'b1;
                    end
                default: begin
                    mode = MODE_NORMAL;
                    rescan = 1'b1;
                end
            endcase
            if (rescan) start_token(c, pos);
            offset = bump(pos);
            if (eot) begin
                flush_pending();
                put(KIND_END, offset, 16'd0, 1'b0);
                clear_state();
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) owed_tokens.push_back(step_tokens[i]);
        endfunction

        function void check_token(token_t got);
            token_t want;
            tokens_seen++;
            if (owed_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token kind=%0d start=%0d", got.kind, got.start);
                return;
            end
            want = owed_tokens.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("token mismatch: want kind=%0d start=%0d len=%0d line=%0d err=%0b last=%0b, got kind=%0d start=%0d len=%0d line=%0d err=%0b last=%0b",
                             want.kind, want.start, want.len, want.line, want.err, want.last,
                             got.kind, got.start, got.len, got.line, got.err, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        format_error;
    logic        last_of_run;

    token_scoreboard board;
    int  bytes_sent;
    int  texts_sent;
    int  idle_cycles;
    bit  calm_phase;     // no idling once set
    bit  hold_output;    // long receiver hold-off
    bit  timed_out;

    source_token_scanner_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_byte(char_byte), .end_of_text(end_of_text),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .start_offset(start_offset),
        .token_length(token_length), .line_number(line_number),
        .format_error(format_error), .last_of_run(last_of_run)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Drive one byte; valid stays high between back-to-back words.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_byte <= c;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        board.note_byte(c, eot);
        bytes_sent++;
        if (eot) texts_sent++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && (i == s.len() - 1));
    endtask

    // Random chunk of C-like source: mostly real tokens, some noise.
    function automatic string random_chunk();
        string pieces [] = '{"int", "main", "const", "break", "continue", "if",
            "else", "getint", "printf", "return", "while", "void", "x_1", "Abc",
            "continue9", "mainx", "0", "12345", "<", "<=", ">", ">=", "!", "!=",
            "=", "==", "+", "-", "*", "/", "%", "&&", "||", "&", "|", ",", ";",
            "(", ")", "[", "]", "{", "}", " ", "\n", "\t", "\r", "// note\n",
            "/* a\n* b **/", "\"ok %d\\n\"", "\"%x\"", "\"a\\t\"", "\"tab\t\"",
            "\"end%\"", "\"end\\\"", "#", "@", "$"};
        string s;
        s = pieces[$urandom_range(0, pieces.size() - 1)];
        if ($urandom_range(0, 15) == 0)
            s = {s, string'(8'($urandom_range(0, 255)))};
        else if ($urandom_range(0, 3) != 0)
            s = {s, " "};
        return s;
    endfunction

    // receiver: random stall bursts, plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else if (hold_output) out_stall <= 1'b1;
        else if (!calm_phase && $urandom_range(0, 6) == 0) out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 2) != 0 && !calm_phase) out_stall <= 1'b1;
        else out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        token_t got;
        if (rst_n && out_valid && !out_stall) begin
            got = {token_kind, start_offset, token_length, line_number, format_error,
                   last_of_run};
            board.check_token(got);
        end
    end

    // watchdog on cycles with no word accepted
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        string chunk;
        int    n;
        board = new();
        board.clear_state();
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_byte = 8'h00;
        end_of_text = 1'b0;
        out_stall = 1'b0;
        calm_phase = 1'b0;
        hold_output = 1'b0;
        timed_out = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: keywords, operators, format errors, unterminated string
        send_text("int continue x9<=a!b&c||d==e>=f\"%d\\n\"", 1'b0);
        send_text("\"\\q%x\t\"/*\n*/5&&/", 1'b1);
        send_text("\"open\\", 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_text("//c", 1'b1);

        // long receiver hold-off while the sender keeps pushing
        fork
            begin
                hold_output = 1'b1;
                repeat (60) @(posedge clk);
                hold_output = 1'b0;
            end
            send_text("{;;}()[],+-*%<>", 1'b0);
        join
        send_byte(" ", 1'b1);

        // random texts of well-formed chunks with noise
        n = 0;
        while (n < 250) begin
            chunk = random_chunk();
            if (n > 210) calm_phase = 1'b1;
            send_text(chunk, $urandom_range(0, 30) == 0);
            n += chunk.len();
        end
        send_text("\"", 1'b1);

        in_valid <= 1'b0;
        n = 0;
        while (board.owed_tokens.size() != 0 && n < WATCHDOG_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);

        $display("scanned %0d bytes in %0d texts, %0d tokens compared",
                 bytes_sent, texts_sent, board.tokens_seen);
        if (board.mismatches == 0 && board.owed_tokens.size() == 0)
            $display("No mismatches found");
        else begin
            $display("%0d mismatches, %0d tokens never seen", board.mismatches,
                     board.owed_tokens.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== source_token_scanner_top.f =====
+incdir+design
design/sts_pkg.sv
design/sts_core.sv
design/sts_outq.sv
design/source_token_scanner_top.sv
tb/source_token_scanner_top_test.sv
